>>> rtl/bamboo_trim_scheduler_unit_defines.svh
// Assertion macros for the bamboo trim scheduler.
// Used by rtl/bamboo_trim_scheduler_unit.sv; expects clk and rst_n in scope.
`ifndef BAMBOO_TRIM_SCHEDULER_UNIT_DEFINES_SVH
`define BAMBOO_TRIM_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bts_pkg.sv
// Package for the bamboo trim scheduler: sizes, codes, item types, FSM states.
// No dependencies.
package bts_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int HEIGHT_W  = 16;
    localparam int RATE_W    = 8;
    localparam int ENTRY_W   = RATE_W + HEIGHT_W;
    localparam int ACTIVE_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [HEIGHT_W-1:0] THRESHOLD_RESET = 16'd15;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET    = 5'd5;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DAY  = 1'b1;

    localparam logic POLICY_TALLEST = 1'b0;
    localparam logic POLICY_FASTEST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY_MODE      = 2'd0,
        CFG_HEIGHT_THRESHOLD = 2'd1,
        CFG_ACTIVE_COUNT     = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CUT
    } bts_state_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  entry_index;
        logic [7:0]  growth_rate;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  cut_index;
        logic [15:0] cut_height;
    } out_item_t;

endpackage

>>> rtl/bamboo_trim_scheduler_unit.sv
// Bamboo trim scheduler top level: entry table memory, day scan sequencer, result register.
// Depends on bts_pkg and bamboo_trim_scheduler_unit_defines.svh.

// The block holds a table of ENTRIES entries (rate, height) in one synchronous
// memory with a registered read. A load item (kind = 0) writes one entry, rate
// and height both set to growth_rate, in the cycle it is accepted. A day item
// (kind = 1) walks the table through the single read port: one entry is read
// per cycle, grown with saturation at 65535 and written back the cycle after,
// while a running best picks the entry to cut (tallest, or fastest grower whose
// height strictly exceeds height_threshold; lowest index wins ties, entry 0 when
// nothing qualifies). The chosen entry is then cut back to its rate and one
// result item (cut_index, cut_height before the cut) goes to the output
// register. A day item runs through SCAN, reading entries 0 to n - 1 with
// n = min(active_count, ENTRIES) (entry 0 alone when n = 0), then DRAIN and
// CUT, which waits for a free output register. One item is in work at a time;
// the output register lets the next item start while a result waits.
// The table reads as all zero after reset: a valid bit per entry masks
// entries never written since reset. Configuration writes are taken any time
// (cfg_ready is tied high) and must only be issued while the block is idle.

`include "bamboo_trim_scheduler_unit_defines.svh"

module bamboo_trim_scheduler_unit
    import bts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,

    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item
);

    // ---------------- configuration registers ----------------
    logic                policy_reg;
    logic [HEIGHT_W-1:0] threshold_reg;
    logic [ACTIVE_W-1:0] active_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_TALLEST;
            threshold_reg <= THRESHOLD_RESET;
            active_reg    <= ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POLICY_MODE:      policy_reg    <= cfg_data[0];
                CFG_HEIGHT_THRESHOLD: threshold_reg <= cfg_data[HEIGHT_W-1:0];
                CFG_ACTIVE_COUNT:     active_reg    <= cfg_data[ACTIVE_W-1:0];
                default:              ;  // unknown index: ignored
            endcase
        end
    end

    // Live entry count, clamped to the table size, and the last index walked.
    logic [CNT_W-1:0] live_n;
    logic [IDX_W-1:0] last_idx;

    always_comb
    begin
        if (int'(active_reg) > ENTRIES)
            live_n = CNT_W'(ENTRIES);
        else
            live_n = CNT_W'(active_reg);
        // entry 0 is always read, even with no live entries
        if (live_n == '0)
            last_idx = '0;
        else
            last_idx = IDX_W'(live_n - CNT_W'(1));
    end

    // ---------------- control ----------------
    bts_state_t state_reg, state_next;

    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic             in_fire;
    logic             slot_free;
    logic             cut_fire;
    logic             load_hit;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign load_hit  = (int'(in_item.entry_index) < ENTRIES);

    // ---------------- entry memory ----------------
    logic [ENTRY_W-1:0] mem [ENTRIES];
    logic [ENTRY_W-1:0] mem_q_reg;
    logic               q_vld_reg;
    logic [ENTRIES-1:0] ent_vld_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
            q_vld_reg   <= 1'b0;
        end
        else
        begin
            if (mem_we)
                ent_vld_reg[mem_waddr] <= 1'b1;
            if (rd_en)
                q_vld_reg <= ent_vld_reg[rd_addr];
        end
    end

    // ---------------- scan datapath ----------------
    logic [RATE_W-1:0]   cur_rate;
    logic [HEIGHT_W-1:0] cur_h;
    logic [HEIGHT_W:0]   sum;
    logic [HEIGHT_W-1:0] grown;
    logic [HEIGHT_W-1:0] new_h;
    logic                grow;
    logic                first;
    logic [HEIGHT_W-1:0] best_cmp;
    logic [HEIGHT_W-1:0] cand;
    logic                better;

    logic [IDX_W-1:0]    pick_idx_reg;
    logic [HEIGHT_W-1:0] pick_h_reg;
    logic [RATE_W-1:0]   pick_r_reg;
    logic [HEIGHT_W-1:0] best_reg;

    always_comb
    begin
        // never-written entries read as zero
        cur_rate = q_vld_reg ? mem_q_reg[ENTRY_W-1:HEIGHT_W] : '0;
        cur_h    = q_vld_reg ? mem_q_reg[HEIGHT_W-1:0] : '0;
        sum      = {1'b0, cur_h} + (HEIGHT_W + 1)'(cur_rate);
        grown    = sum[HEIGHT_W] ? '1 : sum[HEIGHT_W-1:0];
        grow     = (CNT_W'(chk_idx_reg) < live_n);
        new_h    = grow ? grown : cur_h;
        first    = (chk_idx_reg == '0);
        best_cmp = first ? '0 : best_reg;
        if (policy_reg == POLICY_FASTEST)
        begin
            cand   = HEIGHT_W'(cur_rate);
            better = (new_h > threshold_reg) && (cand > best_cmp);
        end
        else
        begin
            cand   = new_h;
            better = (new_h > best_cmp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_vld_reg && (better || first))
        begin
            pick_idx_reg <= chk_idx_reg;
            pick_h_reg   <= new_h;
            pick_r_reg   <= cur_rate;
        end
        if (chk_vld_reg)
            best_reg <= better ? cand : best_cmp;
    end

    // ---------------- state machine: next state ----------------
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_item.kind == KIND_DAY)
                begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == last_idx)
                    state_next = ST_DRAIN;
                else
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
            ST_DRAIN:
                state_next = ST_CUT;
            ST_CUT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- state machine: outputs ----------------
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = scan_idx_reg;
        cut_fire  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = chk_idx_reg;
        mem_wdata = {cur_rate, grown};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && in_item.kind == KIND_LOAD && load_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(in_item.entry_index);
                    mem_wdata = {in_item.growth_rate, HEIGHT_W'(in_item.growth_rate)};
                end
            end
            ST_SCAN:
            begin
                rd_en  = 1'b1;
                // write back the entry read last cycle
                mem_we = chk_vld_reg && grow;
            end
            ST_DRAIN:
                mem_we = chk_vld_reg && grow;
            ST_CUT:
            begin
                cut_fire = slot_free;
                if (slot_free)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pick_idx_reg;
                    mem_wdata = {pick_r_reg, HEIGHT_W'(pick_r_reg)};
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            chk_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= rd_en;
            chk_idx_reg  <= rd_addr;
            if (cut_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cut_fire)
        begin
            out_item_reg.cut_index  <= 4'(pick_idx_reg);
            out_item_reg.cut_height <= pick_h_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------- assertions ----------------
    `BTS_ASSERT_NOW(a_no_rw_same_entry, mem_we && rd_en, mem_waddr != rd_addr, "read and write hit the same entry")
    `BTS_ASSERT_NEXT(a_scan_ends, state_reg == ST_SCAN && scan_idx_reg == last_idx, state_reg == ST_DRAIN, "scan did not stop at last entry")
    `BTS_ASSERT_NEXT(a_read_checked, rd_en, chk_vld_reg && chk_idx_reg == $past(rd_addr), "read data not checked")
    `BTS_ASSERT_NEXT(a_cut_reports, state_reg == ST_CUT && slot_free, out_valid_reg && state_reg == ST_IDLE, "cut without result item")

endmodule

>>> sim/bamboo_trim_scheduler_unit_tb.sv
// Self-checking testbench for bamboo_trim_scheduler_unit: drives load and day items, predicts
// every cut item and checks it field by field. Depends on bts_pkg and the RTL top level only.
module bamboo_trim_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    // Watchdog bound: idle cycles with no handshake at all. The longest legal quiet
    // stretch is the receiver hold-off below plus one day scan.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int RX_STALL_CYCLES = 400;
    // A load is written in the cycle it is accepted; give it margin before a register write.
    localparam int SETTLE_CYCLES   = 8;
    // Tail after the last expected cut item: a few day-scan lengths.
    localparam int TAIL_CYCLES     = 60;
    localparam int REPORT_MAX      = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = CFG_POLICY_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;

    // Items waiting to be offered, and cut items predicted but not yet seen.
    in_item_t  stim_q[$];
    out_item_t cut_q[$];

    // Shadow of the garden table and the three registers.
    logic [HEIGHT_W-1:0] height_tbl [ENTRIES];
    logic [RATE_W-1:0]   rate_tbl   [ENTRIES];
    logic                mode_r;
    logic [HEIGHT_W-1:0] thr_r;
    logic [ACTIVE_W-1:0] active_r;

    // in_sent moves at the falling edge, in_done at the rising edge; they differ
    // exactly while an offered item is still waiting for in_ready.
    int unsigned in_sent      = 0;
    int unsigned in_done      = 0;
    int unsigned idle_run     = 0;
    int unsigned fail_count   = 0;
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    logic        rx_stall     = 1'b0;
    logic        rx_stall_req = 1'b0;

    bamboo_trim_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void note_failure(string what);
        if (fail_count < REPORT_MAX)
            $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endfunction

    // Predictor. A load rewrites one entry; a day grows the live entries with
    // saturation, picks the entry to cut and queues the cut item it reports.
    function automatic void grow_and_cut(in_item_t it);
        int unsigned       live;
        int unsigned       best;
        int unsigned       pick;
        logic [HEIGHT_W:0] sum;
        out_item_t         cut;
        if (it.kind == KIND_LOAD)
        begin
            if (it.entry_index < ENTRIES)
            begin
                rate_tbl[it.entry_index]   = it.growth_rate;
                height_tbl[it.entry_index] = HEIGHT_W'(it.growth_rate);
            end
            return;
        end
        // A count past the table size acts as the table size; zero grows nothing.
        live = (active_r > ENTRIES) ? ENTRIES : active_r;
        for (int i = 0; i < live; i++)
        begin
            sum = height_tbl[i] + rate_tbl[i];
            height_tbl[i] = sum[HEIGHT_W] ? {HEIGHT_W{1'b1}} : sum[HEIGHT_W-1:0];
        end
        // Running best starts at zero and must be strictly beaten: lowest index
        // wins ties, entry 0 wins when nothing qualifies.
        best = 0;
        pick = 0;
        for (int i = 0; i < live; i++)
        begin
            if (mode_r == POLICY_FASTEST)
            begin
                if (height_tbl[i] > thr_r && rate_tbl[i] > best)
                begin
                    best = rate_tbl[i];
                    pick = i;
                end
            end
            else if (height_tbl[i] > best)
            begin
                best = height_tbl[i];
                pick = i;
            end
        end
        cut.cut_index  = IDX_W'(pick);
        cut.cut_height = height_tbl[pick];
        height_tbl[pick] = HEIGHT_W'(rate_tbl[pick]);
        cut_q.push_back(cut);
    endfunction

    function automatic in_item_t rand_item(int unsigned day_pct);
        in_item_t it;
        it.kind        = ($urandom_range(0, 99) < day_pct) ? KIND_DAY : KIND_LOAD;
        it.entry_index = 4'($urandom_range(0, 15));
        // Mostly full-range rates, some small ones so slow growers hang around.
        it.growth_rate = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                                     : 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic void queue_item(logic kind, int unsigned idx, int unsigned rate);
        in_item_t it;
        it.kind        = kind;
        it.entry_index = idx[3:0];
        it.growth_rate = rate[7:0];
        stim_q.push_back(it);
    endfunction

    // Monitor: everything is sampled at the rising edge, before the block's
    // own updates of this edge take effect.
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                grow_and_cut(in_item);
                in_done++;
            end
            if (out_valid && out_ready)
            begin
                if (cut_q.size() == 0)
                begin
                    note_failure($sformatf("cut item with none expected: index %0d height %0d",
                                           out_item.cut_index, out_item.cut_height));
                end
                else
                begin
                    want = cut_q.pop_front();
                    if (out_item.cut_index !== want.cut_index)
                        note_failure($sformatf("cut_index expected %0d got %0d",
                                               want.cut_index, out_item.cut_index));
                    if (out_item.cut_height !== want.cut_height)
                        note_failure($sformatf("cut_height expected %0d got %0d",
                                               want.cut_height, out_item.cut_height));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_run = 0;
            end
            else
            begin
                idle_run++;
                if (idle_run >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles", idle_run);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Sender: offers the next queued item once the previous one is taken.
    // Back-to-back items keep in_valid high with one assignment per edge.
    always @(negedge clk)
    begin : sender
        if (rst_n && in_sent == in_done)
        begin
            if (stim_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
            begin
                in_item  <= stim_q.pop_front();
                in_valid <= 1'b1;
                in_sent++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, forced low during the long hold-off.
    always @(negedge clk)
    begin : receiver
        if (rst_n)
            out_ready <= !rx_stall && ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Long receiver hold-off, counted here at rising edges so the receiver
    // (falling edge) never races it. The sender keeps offering meanwhile, so the
    // output register and the item in work both fill and in_ready drops.
    initial
    begin : rx_hold_off
        wait (rx_stall_req);
        @(posedge clk);
        rx_stall = 1'b1;
        repeat (RX_STALL_CYCLES) @(posedge clk);
        rx_stall = 1'b0;
    end

    // Register write; the shadow copy follows at the accepting edge.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_POLICY_MODE:      mode_r   = value[0];
            CFG_HEIGHT_THRESHOLD: thr_r    = value;
            CFG_ACTIVE_COUNT:     active_r = value[ACTIVE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: nothing queued, nothing offered, every cut item back.
    task automatic drain();
        while (stim_q.size() != 0 || in_sent != in_done || cut_q.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only on an idle block: drain, let a trailing load
    // finish, then write all three.
    task automatic program_regs(input logic mode, input logic [HEIGHT_W-1:0] thr,
                                input logic [ACTIVE_W-1:0] active);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_POLICY_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_HEIGHT_THRESHOLD, thr);
        write_reg(CFG_ACTIVE_COUNT, CFG_DATA_W'(active));
    endtask

    task automatic random_phase(input logic mode, input logic [HEIGHT_W-1:0] thr,
                                input logic [ACTIVE_W-1:0] active,
                                input int unsigned count, input int unsigned day_pct);
        program_regs(mode, thr, active);
        repeat (count) stim_q.push_back(rand_item(day_pct));
    endtask

    initial
    begin : stimulus
        for (int i = 0; i < ENTRIES; i++)
        begin
            height_tbl[i] = '0;
            rate_tbl[i]   = '0;
        end
        mode_r   = POLICY_TALLEST;
        thr_r    = THRESHOLD_RESET;
        active_r = ACTIVE_RESET;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles often, receiver more so.
        in_idle_pct  = 29;
        out_idle_pct = 61;

        // Directed, on reset settings (tallest, threshold 15, five live entries).
        queue_item(KIND_DAY, 0, 0);      // empty table: nothing beats zero, entry 0
        queue_item(KIND_LOAD, 0, 0);
        queue_item(KIND_LOAD, 15, 255);  // outside the live range, never grows
        queue_item(KIND_LOAD, 1, 7);
        queue_item(KIND_LOAD, 2, 7);     // equal to entry 1: lower index wins the tie
        queue_item(KIND_LOAD, 4, 3);
        queue_item(KIND_DAY, 15, 255);
        queue_item(KIND_DAY, 0, 0);
        queue_item(KIND_LOAD, 3, 255);
        queue_item(KIND_DAY, 0, 0);
        queue_item(KIND_DAY, 0, 0);
        queue_item(KIND_LOAD, 0, 255);
        queue_item(KIND_DAY, 0, 0);
        queue_item(KIND_LOAD, 15, 0);
        queue_item(KIND_DAY, 0, 0);
        queue_item(KIND_LOAD, 1, 128);
        queue_item(KIND_LOAD, 2, 128);
        queue_item(KIND_DAY, 0, 0);
        queue_item(KIND_DAY, 0, 0);

        random_phase(POLICY_TALLEST, 16'($urandom_range(0, 65535)), 5'd16, 150, 55);
        // Threshold zero, one live entry.
        random_phase(POLICY_FASTEST, 16'd0, 5'd1, 100, 60);
        // Count of zero: nothing grows, entry 0 is cut back every day.
        random_phase(POLICY_TALLEST, 16'd15, 5'd0, 40, 60);

        // Roles swapped: receiver idles less than the sender.
        drain();
        in_idle_pct  = 61;
        out_idle_pct = 29;

        // Saturation: threshold at the top so nothing qualifies and entry 0 is
        // always cut, count past the table size; fast entries run into 65535.
        program_regs(POLICY_FASTEST, 16'hFFFF, 5'd31);
        queue_item(KIND_LOAD, 0, $urandom_range(0, 255));
        for (int i = 1; i < ENTRIES; i++)
            queue_item(KIND_LOAD, i, $urandom_range(240, 255));
        repeat (290) queue_item(KIND_DAY, $urandom_range(0, 15), $urandom_range(0, 255));
        // Saturated entries now qualify; equal rates tie on lowest index.
        random_phase(POLICY_FASTEST, 16'hFFFE, 5'd16, 60, 90);

        // No idling on either side.
        drain();
        in_idle_pct  = 0;
        out_idle_pct = 0;

        random_phase(POLICY_TALLEST, 16'($urandom_range(0, 65535)),
                     5'($urandom_range(1, 16)), 120, 85);
        rx_stall_req = 1'b1;
        random_phase(POLICY_FASTEST, 16'($urandom_range(0, 600)),
                     5'($urandom_range(1, 16)), 200, 70);
        random_phase(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                     5'd16, 100, 70);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (cut_q.size() != 0)
            note_failure($sformatf("%0d cut items never arrived", cut_q.size()));
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bts_pkg.sv
rtl/bamboo_trim_scheduler_unit.sv
sim/bamboo_trim_scheduler_unit_tb.sv
